// File: rtl/sfp_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sfp_pkg
// Shared types, codes and helpers of the snapshot format parser.
// ----------------------------------------------------------------------------
package sfp_pkg;

    localparam logic [63:0] FNV_BASIS  = 64'hCBF2_9CE4_8422_2325;
    localparam logic [31:0] MAGIC_WORD = 32'h4244_5247;
    localparam logic [31:0] FORMAT_VER = 32'd1;
    localparam logic [7:0]  TYPE_LIST  = 8'd1;
    localparam logic [4:0]  WIN_DEPTH  = 5'd8;
    localparam logic [4:0]  MIN_BYTES  = 5'd24;

    // token kinds
    localparam logic [2:0] TK_KEY      = 3'd0;
    localparam logic [2:0] TK_STR      = 3'd1;
    localparam logic [2:0] TK_ELEM     = 3'd2;
    localparam logic [2:0] TK_ELEM_END = 3'd3;
    localparam logic [2:0] TK_ENTRY    = 3'd4;
    localparam logic [2:0] TK_VERDICT  = 3'd5;

    // verdict codes
    localparam logic [2:0] V_OK        = 3'd0;
    localparam logic [2:0] V_SHORT     = 3'd1;
    localparam logic [2:0] V_CHECKSUM  = 3'd2;
    localparam logic [2:0] V_MAGIC     = 3'd3;
    localparam logic [2:0] V_VERSION   = 3'd4;
    localparam logic [2:0] V_TRUNC     = 3'd5;

    typedef enum logic [3:0] {
        PH_MAGIC, PH_VERSION, PH_COUNT, PH_KEYLEN, PH_KEY, PH_TYPE, PH_HASTTL,
        PH_EXPIRY, PH_STRLEN, PH_STRVAL, PH_LISTCNT, PH_ELEMLEN, PH_ELEMVAL,
        PH_DONE, PH_ERROR
    } t_phase;

    typedef struct packed {
        logic [2:0]  kind;
        logic [7:0]  tbyte;
        logic        is_list;
        logic        has_exp;
        logic [63:0] exp_ms;
        logic        keep;
        logic [2:0]  verdict;
        logic        last;
    } t_result;

    // status of the delay line and hash toward the parser
    typedef struct packed {
        logic       leave_valid;
        logic [7:0] leave_byte;
        logic       too_short;
        logic       sum_ok;
    } t_front_stat;

    // FNV prime is 2^40 + 0x1B3: shifts and adds only
    function automatic logic [63:0] fnv_mul(input logic [63:0] h);
        fnv_mul = (h << 40) + (h << 8) + (h << 7) + (h << 5)
                + (h << 4) + (h << 1) + h;
    endfunction

    function automatic t_result mk_tok(input logic [2:0] kind, input logic [7:0] b);
        t_result r;
        r       = '0;
        r.kind  = kind;
        r.tbyte = b;
        mk_tok  = r;
    endfunction

endpackage

// File: rtl/snapshot_format_parser.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// snapshot_format_parser
// Streaming validator and tokenizer for a key-value snapshot file.
// ----------------------------------------------------------------------------
// Usage:
//   Slave channel: one file byte per request, tlast on the last file byte.
//   Master channel: tokens; tuser is the token kind, tlast ends the tokens
//   caused by one input byte. The last byte adds a verdict token unless its
//   run already holds three tokens; every token of that run carries the verdict.
//   load_time_ms is written through i_cfg_wen / i_cfg_wdata while idle.
// Latency and throughput:
//   Tokens of a byte appear in the cycle after it is taken. A byte is taken
//   every cycle while each yields at most one token and the master side is
//   ready; else the next byte waits until the three-slot result buffer,
//   draining one token a cycle while the master side is ready, can take its run.
//   The first eight bytes of a file only fill the checksum delay line.
// Reset and stall:
//   Reset clears the parser, hash, delay line, buffer and load time. After
//   the last byte of a file the parser, hash and delay line return to reset.
//   A stalled master side holds its token; the input stops when the buffer
//   cannot take a full run.
// ----------------------------------------------------------------------------
module snapshot_format_parser import sfp_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_wen,
    input  logic [63:0] i_cfg_wdata,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [7:0]  i_s_tdata,   // [7:0] file_byte
    input  logic        i_s_tlast,
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    // [7:0] token_byte, [8] entry_is_list, [9] entry_has_expiry,
    // [73:10] entry_expiry_ms, [74] keep_entry, [77:75] verdict, [79:78] zero
    output logic [79:0] o_m_tdata,
    output logic [2:0]  o_m_tuser,   // [2:0] token_kind
    output logic        o_m_tlast
);

    logic [63:0] r_load_time;
    logic        step;
    t_front_stat stat;
    t_result     res [3];
    logic [1:0]  cnt;
    t_result     head;

    // load time register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_load_time <= '0;
        end else if (i_cfg_wen) begin
            r_load_time <= i_cfg_wdata;
        end
    end

    assign step = i_s_tvalid && o_s_tready;

    sfp_front u_front (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_step (step),
        .i_fin  (i_s_tlast),
        .i_byte (i_s_tdata),
        .o_stat (stat)
    );

    sfp_parser u_parser (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_step     (step),
        .i_fin      (i_s_tlast),
        .i_stat     (stat),
        .i_load_time(r_load_time),
        .o_res      (res),
        .o_cnt      (cnt)
    );

    sfp_outq u_outq (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (step),
        .i_res      (res),
        .i_cnt      (cnt),
        .i_pop_ready(i_m_tready),
        .o_can_push (o_s_tready),
        .o_valid    (o_m_tvalid),
        .o_head     (head)
    );

    // output packing
    assign o_m_tdata = {2'b00, head.verdict, head.keep, head.exp_ms,
                        head.has_exp, head.is_list, head.tbyte};
    assign o_m_tuser = head.kind;
    assign o_m_tlast = head.last;

endmodule

// File: rtl/sfp_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sfp_front
// Eight-byte checksum delay line, byte counter and running FNV-1a hash.
// ----------------------------------------------------------------------------
module sfp_front import sfp_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_step,
    input  logic        i_fin,
    input  logic [7:0]  i_byte,
    output t_front_stat o_stat
);

    logic [7:0]  r_win [8];
    logic [7:0]  n_win [8];
    logic [63:0] r_hash, n_hash;
    logic [4:0]  r_seen, n_seen;
    logic [63:0] stored;

    // next window, hash and count for this byte
    always_comb begin
        for (int i = 0; i < 7; i++) begin
            n_win[i] = r_win[i + 1];
        end
        n_win[7] = i_byte;
        n_hash   = (r_seen >= WIN_DEPTH) ? fnv_mul(r_hash ^ {56'd0, r_win[0]}) : r_hash;
        n_seen   = (r_seen < MIN_BYTES) ? r_seen + 5'd1 : r_seen;
        for (int i = 0; i < 8; i++) begin
            stored[8*i +: 8] = n_win[i];
        end
    end

    assign o_stat.leave_valid = (r_seen >= WIN_DEPTH);
    assign o_stat.leave_byte  = r_win[0];
    assign o_stat.too_short   = (n_seen < MIN_BYTES);
    assign o_stat.sum_ok      = (stored == n_hash);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || (i_step && i_fin)) begin
            r_hash <= FNV_BASIS;
            r_seen <= '0;
            for (int i = 0; i < 8; i++) begin
                r_win[i] <= '0;
            end
        end else if (i_step) begin
            r_hash <= n_hash;
            r_seen <= n_seen;
            for (int i = 0; i < 8; i++) begin
                r_win[i] <= n_win[i];
            end
        end
    end

endmodule

// File: rtl/sfp_parser.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sfp_parser
// Header and entry parser; turns one delayed byte into up to three tokens.
// ----------------------------------------------------------------------------
module sfp_parser import sfp_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_step,
    input  logic        i_fin,
    input  t_front_stat i_stat,
    input  logic [63:0] i_load_time,
    output t_result     o_res [3],
    output logic [1:0]  o_cnt
);

    t_phase      r_phase, n_phase;
    logic [2:0]  r_idx, n_idx;
    logic [63:0] r_acc, n_acc;
    logic [31:0] r_sleft, n_sleft;
    logic [63:0] r_entries, n_entries;
    logic [31:0] r_elems, n_elems;
    logic        r_is_list, n_is_list;
    logic        r_has_exp, n_has_exp;
    logic [63:0] r_exp, n_exp;
    logic [2:0]  r_err, n_err;

    logic [63:0] acc_new;
    logic        done4, done8, fin_end_entry;
    logic [1:0]  k;
    logic [2:0]  verdict;
    logic [7:0]  b;
    t_result     res [3];
    t_result     ent;

    always_comb begin
        n_phase   = r_phase;
        n_idx     = r_idx;
        n_acc     = r_acc;
        n_sleft   = r_sleft;
        n_entries = r_entries;
        n_elems   = r_elems;
        n_is_list = r_is_list;
        n_has_exp = r_has_exp;
        n_exp     = r_exp;
        n_err     = r_err;
        b         = i_stat.leave_byte;
        k         = 2'd0;
        verdict   = V_OK;
        fin_end_entry = 1'b0;
        for (int i = 0; i < 3; i++) begin
            res[i] = '0;
        end

        // little-endian field collection
        acc_new = r_acc | ({56'd0, b} << {r_idx, 3'b000});
        done4   = (r_idx == 3'd3);
        done8   = (r_idx == 3'd7);

        // entry end token from the current entry state
        ent         = mk_tok(TK_ENTRY, 8'd0);
        ent.is_list = r_is_list;
        ent.has_exp = r_has_exp;
        ent.exp_ms  = r_has_exp ? r_exp : 64'd0;
        ent.keep    = !(r_has_exp && ($signed(r_exp) <= $signed(i_load_time)));

        if (i_step && i_stat.leave_valid) begin
            unique case (r_phase)
                PH_MAGIC, PH_VERSION, PH_KEYLEN, PH_STRLEN, PH_LISTCNT, PH_ELEMLEN: begin
                    n_idx = done4 ? 3'd0 : r_idx + 3'd1;
                    n_acc = done4 ? 64'd0 : acc_new;
                    if (done4) begin
                        unique case (r_phase)
                            PH_MAGIC: begin
                                if (acc_new[31:0] != MAGIC_WORD) begin
                                    n_err = V_MAGIC; n_phase = PH_ERROR;
                                end else n_phase = PH_VERSION;
                            end
                            PH_VERSION: begin
                                if (acc_new[31:0] != FORMAT_VER) begin
                                    n_err = V_VERSION; n_phase = PH_ERROR;
                                end else n_phase = PH_COUNT;
                            end
                            PH_KEYLEN: begin
                                n_sleft = acc_new[31:0];
                                n_phase = (acc_new[31:0] == 32'd0) ? PH_TYPE : PH_KEY;
                            end
                            PH_STRLEN: begin
                                n_sleft = acc_new[31:0];
                                if (acc_new[31:0] == 32'd0) fin_end_entry = 1'b1;
                                else n_phase = PH_STRVAL;
                            end
                            PH_LISTCNT: begin
                                n_elems = acc_new[31:0];
                                if (acc_new[31:0] == 32'd0) fin_end_entry = 1'b1;
                                else n_phase = PH_ELEMLEN;
                            end
                            default: begin
                                // element length
                                n_sleft = acc_new[31:0];
                                if (acc_new[31:0] == 32'd0) begin
                                    res[0]  = mk_tok(TK_ELEM_END, 8'd0);
                                    k       = 2'd1;
                                    n_elems = r_elems - 32'd1;
                                    if (n_elems == 32'd0) fin_end_entry = 1'b1;
                                    else n_phase = PH_ELEMLEN;
                                end else n_phase = PH_ELEMVAL;
                            end
                        endcase
                    end
                end
                PH_COUNT, PH_EXPIRY: begin
                    n_idx = done8 ? 3'd0 : r_idx + 3'd1;
                    n_acc = done8 ? 64'd0 : acc_new;
                    if (done8) begin
                        if (r_phase == PH_COUNT) begin
                            n_entries = acc_new;
                            n_phase   = (acc_new == 64'd0) ? PH_DONE : PH_KEYLEN;
                        end else begin
                            n_exp   = acc_new;
                            n_phase = r_is_list ? PH_LISTCNT : PH_STRLEN;
                        end
                    end
                end
                PH_KEY: begin
                    res[0]  = mk_tok(TK_KEY, b);
                    k       = 2'd1;
                    n_sleft = r_sleft - 32'd1;
                    if (n_sleft == 32'd0) n_phase = PH_TYPE;
                end
                PH_TYPE: begin
                    n_is_list = (b == TYPE_LIST);
                    n_phase   = PH_HASTTL;
                end
                PH_HASTTL: begin
                    n_has_exp = (b != 8'd0);
                    n_phase   = (b != 8'd0) ? PH_EXPIRY : (r_is_list ? PH_LISTCNT : PH_STRLEN);
                end
                PH_STRVAL: begin
                    res[0]  = mk_tok(TK_STR, b);
                    k       = 2'd1;
                    n_sleft = r_sleft - 32'd1;
                    if (n_sleft == 32'd0) fin_end_entry = 1'b1;
                end
                PH_ELEMVAL: begin
                    res[0]  = mk_tok(TK_ELEM, b);
                    n_sleft = r_sleft - 32'd1;
                    if (n_sleft == 32'd0) begin
                        res[1]  = mk_tok(TK_ELEM_END, 8'd0);
                        k       = 2'd2;
                        n_elems = r_elems - 32'd1;
                        if (n_elems == 32'd0) fin_end_entry = 1'b1;
                        else n_phase = PH_ELEMLEN;
                    end else k = 2'd1;
                end
                default: begin
                end
            endcase

            // close the entry
            if (fin_end_entry) begin
                res[k]    = ent;
                k         = k + 2'd1;
                n_has_exp = 1'b0;
                n_exp     = 64'd0;
                n_is_list = 1'b0;
                n_entries = r_entries - 64'd1;
                n_phase   = (n_entries == 64'd0) ? PH_DONE : PH_KEYLEN;
            end
        end

        // verdict on the last byte of the file
        if (i_step && i_fin) begin
            if (i_stat.too_short)        verdict = V_SHORT;
            else if (!i_stat.sum_ok)     verdict = V_CHECKSUM;
            else if (n_err != V_OK)      verdict = n_err;
            else if (n_phase != PH_DONE) verdict = V_TRUNC;
            else                         verdict = V_OK;
            if (k != 2'd3) begin
                res[k] = mk_tok(TK_VERDICT, 8'd0);
                k      = k + 2'd1;
            end
            for (int i = 0; i < 3; i++) begin
                res[i].verdict = verdict;
            end
        end

        for (int i = 0; i < 3; i++) begin
            res[i].last = (k == 2'(i + 1));
        end
    end

    assign o_res = res;
    assign o_cnt = k;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || (i_step && i_fin)) begin
            r_phase   <= PH_MAGIC;
            r_idx     <= '0;
            r_acc     <= '0;
            r_sleft   <= '0;
            r_entries <= '0;
            r_elems   <= '0;
            r_is_list <= 1'b0;
            r_has_exp <= 1'b0;
            r_exp     <= '0;
            r_err     <= V_OK;
        end else if (i_step) begin
            r_phase   <= n_phase;
            r_idx     <= n_idx;
            r_acc     <= n_acc;
            r_sleft   <= n_sleft;
            r_entries <= n_entries;
            r_elems   <= n_elems;
            r_is_list <= n_is_list;
            r_has_exp <= n_has_exp;
            r_exp     <= n_exp;
            r_err     <= n_err;
        end
    end

endmodule

// File: rtl/sfp_outq.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sfp_outq
// Three-slot result buffer: loads whole runs, drains a token each ready cycle.
// ----------------------------------------------------------------------------
module sfp_outq import sfp_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_push,
    input  t_result    i_res [3],
    input  logic [1:0] i_cnt,
    input  logic       i_pop_ready,
    output logic       o_can_push,
    output logic       o_valid,
    output t_result    o_head
);

    t_result    r_q [3];
    logic [1:0] r_cnt;
    logic       pop;

    assign o_valid    = (r_cnt != 2'd0);
    assign o_head     = r_q[0];
    assign pop        = o_valid && i_pop_ready;
    // a new run loads only into a buffer that is empty after this cycle
    assign o_can_push = (r_cnt == 2'd0) || ((r_cnt == 2'd1) && i_pop_ready);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else if (i_push) begin
            r_cnt <= i_cnt;
        end else if (pop) begin
            r_cnt <= r_cnt - 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_q <= i_res;
        end else if (pop) begin
            r_q[0] <= r_q[1];
            r_q[1] <= r_q[2];
        end
    end

endmodule

// File: tb/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for snapshot_format_parser.
// Builds snapshot files (well formed, corrupted, short, noise), streams them
// byte by byte with random gaps on both channels, and checks every token
// against a cycle-free model of the tokenizer, hash and verdict logic.
// ----------------------------------------------------------------------------
module testbench;
    import sfp_pkg::*;

    localparam int FK_OK       = 0;
    localparam int FK_MAGIC    = 1;
    localparam int FK_VERSION  = 2;
    localparam int FK_TRUNC    = 3;
    localparam int FK_CHECKSUM = 4;
    localparam int FK_SHORT    = 5;
    localparam int FK_TRAIL    = 6;
    localparam int FK_NOISE    = 7;

    typedef struct {
        logic [7:0] b;
        logic       fin;
    } t_file_byte;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_cfg_wen = 1'b0;
    logic [63:0] i_cfg_wdata = '0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata = '0;
    logic        s_tlast = 1'b0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [79:0] m_tdata;
    logic [2:0]  m_tuser;
    logic        m_tlast;

    snapshot_format_parser DUT (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_wen  (i_cfg_wen),
        .i_cfg_wdata(i_cfg_wdata),
        .i_s_tvalid (s_tvalid),
        .o_s_tready (s_tready),
        .i_s_tdata  (s_tdata),
        .i_s_tlast  (s_tlast),
        .o_m_tvalid (m_tvalid),
        .i_m_tready (m_tready),
        .o_m_tdata  (m_tdata),
        .o_m_tuser  (m_tuser),
        .o_m_tlast  (m_tlast)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    t_file_byte  file_q[$];
    t_result     token_q[$];
    logic [7:0]  file_buf[$];
    int          send_idle_pct = 0;
    int          recv_idle_pct = 0;
    int          mismatches = 0;
    int          tokens_checked = 0;
    int          bytes_sent = 0;
    int          files_built = 0;

    // model state
    logic [63:0] load_time;
    logic [7:0]  p_win[8];
    logic [63:0] p_hash;
    int          p_seen;
    t_phase      p_phase;
    int          p_fidx;
    logic [63:0] p_acc;
    logic [31:0] p_strleft;
    logic [63:0] p_entries;
    logic [31:0] p_elems;
    logic        p_is_list;
    logic        p_has_exp;
    logic [63:0] p_exp;
    logic [2:0]  p_err;
    t_result     tok_buf[3];
    int          tok_n;

    function automatic logic [63:0] fnv_fold(input logic [63:0] h, input logic [7:0] b);
        return (h ^ {56'd0, b}) * 64'd1099511628211;
    endfunction

    function automatic void clear_parser();
        foreach (p_win[i]) p_win[i] = '0;
        p_hash    = FNV_BASIS;
        p_seen    = 0;
        p_phase   = PH_MAGIC;
        p_fidx    = 0;
        p_acc     = '0;
        p_strleft = '0;
        p_entries = '0;
        p_elems   = '0;
        p_is_list = 1'b0;
        p_has_exp = 1'b0;
        p_exp     = '0;
        p_err     = V_OK;
    endfunction

    function automatic void add_token(input logic [2:0] kind, input logic [7:0] b);
        if (tok_n < 3) begin
            tok_buf[tok_n] = '0;
            tok_buf[tok_n].kind = kind;
            tok_buf[tok_n].tbyte = b;
            tok_n++;
        end
    endfunction

    // little-endian field collection; 1 when complete
    function automatic bit take_field(input logic [7:0] b, input int len);
        p_acc |= {56'd0, b} << (8 * p_fidx);
        if (p_fidx + 1 >= len) begin
            p_fidx = 0;
            return 1'b1;
        end
        p_fidx++;
        return 1'b0;
    endfunction

    function automatic logic [63:0] take_value();
        logic [63:0] v;
        v = p_acc;
        p_acc = '0;
        return v;
    endfunction

    function automatic void close_entry();
        add_token(TK_ENTRY, 8'd0);
        tok_buf[tok_n-1].is_list = p_is_list;
        tok_buf[tok_n-1].has_exp = p_has_exp;
        tok_buf[tok_n-1].exp_ms  = p_has_exp ? p_exp : 64'd0;
        tok_buf[tok_n-1].keep    = !(p_has_exp && ($signed(p_exp) <= $signed(load_time)));
        p_has_exp = 1'b0;
        p_exp     = '0;
        p_is_list = 1'b0;
        p_entries = p_entries - 1;
        p_phase   = (p_entries == 0) ? PH_DONE : PH_KEYLEN;
    endfunction

    function automatic void close_element();
        add_token(TK_ELEM_END, 8'd0);
        p_elems = p_elems - 1;
        if (p_elems == 0) close_entry();
        else p_phase = PH_ELEMLEN;
    endfunction

    // parser fed by the byte leaving the delay line
    function automatic void parse_leaving(input logic [7:0] b);
        case (p_phase)
            PH_MAGIC: begin
                if (take_field(b, 4)) begin
                    if (take_value() != {32'd0, MAGIC_WORD}) begin
                        p_err = V_MAGIC;
                        p_phase = PH_ERROR;
                    end else p_phase = PH_VERSION;
                end
            end
            PH_VERSION: begin
                if (take_field(b, 4)) begin
                    if (take_value() != {32'd0, FORMAT_VER}) begin
                        p_err = V_VERSION;
                        p_phase = PH_ERROR;
                    end else p_phase = PH_COUNT;
                end
            end
            PH_COUNT: begin
                if (take_field(b, 8)) begin
                    p_entries = take_value();
                    p_phase = (p_entries == 0) ? PH_DONE : PH_KEYLEN;
                end
            end
            PH_KEYLEN: begin
                if (take_field(b, 4)) begin
                    p_strleft = 32'(take_value());
                    p_phase = (p_strleft == 0) ? PH_TYPE : PH_KEY;
                end
            end
            PH_KEY: begin
                add_token(TK_KEY, b);
                p_strleft = p_strleft - 1;
                if (p_strleft == 0) p_phase = PH_TYPE;
            end
            PH_TYPE: begin
                p_is_list = (b == TYPE_LIST);
                p_phase = PH_HASTTL;
            end
            PH_HASTTL: begin
                p_has_exp = (b != 0);
                p_phase = p_has_exp ? PH_EXPIRY : (p_is_list ? PH_LISTCNT : PH_STRLEN);
            end
            PH_EXPIRY: begin
                if (take_field(b, 8)) begin
                    p_exp = take_value();
                    p_phase = p_is_list ? PH_LISTCNT : PH_STRLEN;
                end
            end
            PH_STRLEN: begin
                if (take_field(b, 4)) begin
                    p_strleft = 32'(take_value());
                    if (p_strleft == 0) close_entry();
                    else p_phase = PH_STRVAL;
                end
            end
            PH_STRVAL: begin
                add_token(TK_STR, b);
                p_strleft = p_strleft - 1;
                if (p_strleft == 0) close_entry();
            end
            PH_LISTCNT: begin
                if (take_field(b, 4)) begin
                    p_elems = 32'(take_value());
                    if (p_elems == 0) close_entry();
                    else p_phase = PH_ELEMLEN;
                end
            end
            PH_ELEMLEN: begin
                if (take_field(b, 4)) begin
                    p_strleft = 32'(take_value());
                    if (p_strleft == 0) close_element();
                    else p_phase = PH_ELEMVAL;
                end
            end
            PH_ELEMVAL: begin
                add_token(TK_ELEM, b);
                p_strleft = p_strleft - 1;
                if (p_strleft == 0) close_element();
            end
            default: ;
        endcase
    endfunction

    // expected tokens for one accepted file byte
    function automatic void predict_tokens(input logic [7:0] b, input logic fin);
        logic [63:0] stored;
        logic [2:0]  vd;
        tok_n = 0;
        if (p_seen >= 8) begin
            p_hash = fnv_fold(p_hash, p_win[0]);
            parse_leaving(p_win[0]);
        end
        for (int i = 0; i < 7; i++) p_win[i] = p_win[i+1];
        p_win[7] = b;
        if (p_seen < 24) p_seen++;
        if (fin) begin
            stored = {p_win[7], p_win[6], p_win[5], p_win[4],
                      p_win[3], p_win[2], p_win[1], p_win[0]};
            if (p_seen < 24) vd = V_SHORT;
            else if (stored != p_hash) vd = V_CHECKSUM;
            else if (p_err != V_OK) vd = p_err;
            else if (p_phase != PH_DONE) vd = V_TRUNC;
            else vd = V_OK;
            if (tok_n < 3) add_token(TK_VERDICT, 8'd0);
            for (int i = 0; i < tok_n; i++) tok_buf[i].verdict = vd;
            clear_parser();
        end
        if (tok_n > 0) tok_buf[tok_n-1].last = 1'b1;
        for (int i = 0; i < tok_n; i++) token_q = {token_q, tok_buf[i]};
    endfunction

    // ---------------- file builder ----------------
    function automatic void put32(input logic [31:0] v);
        for (int i = 0; i < 4; i++) file_buf = {file_buf, v[8*i +: 8]};
    endfunction

    function automatic void put64(input logic [63:0] v);
        for (int i = 0; i < 8; i++) file_buf = {file_buf, v[8*i +: 8]};
    endfunction

    function automatic void put_bytes(input int n);
        for (int i = 0; i < n; i++) file_buf = {file_buf, 8'($urandom_range(0, 255))};
    endfunction

    function automatic logic [63:0] pick_expiry();
        case ($urandom_range(0, 6))
            0: return 64'h8000_0000_0000_0000;
            1: return 64'h7FFF_FFFF_FFFF_FFFF;
            2: return load_time;
            3: return load_time - 1;
            4: return load_time + 1;
            default: return {$urandom, $urandom};
        endcase
    endfunction

    function automatic void put_entry();
        logic lst;
        int   n;
        n = $urandom_range(0, 3);
        put32(n);
        put_bytes(n);
        lst = $urandom_range(0, 1);
        if (lst) file_buf = {file_buf, TYPE_LIST};
        else begin
            case ($urandom_range(0, 2))
                0: file_buf = {file_buf, 8'd0};
                1: file_buf = {file_buf, 8'hFF};
                default: file_buf = {file_buf, 8'($urandom_range(2, 254))};
            endcase
        end
        if ($urandom_range(0, 1)) file_buf = {file_buf, 8'd0};
        else begin
            file_buf = {file_buf, 8'($urandom_range(1, 255))};
            put64(pick_expiry());
        end
        if (lst) begin
            n = $urandom_range(0, 3);
            put32(n);
            for (int e = 0; e < n; e++) begin
                int len;
                len = $urandom_range(0, 3);
                put32(len);
                put_bytes(len);
            end
        end else begin
            n = $urandom_range(0, 4);
            put32(n);
            put_bytes(n);
        end
    endfunction

    function automatic void queue_file(input int kind);
        logic [63:0] h;
        int          n;
        t_file_byte  fb;
        file_buf.delete();
        if (kind == FK_SHORT) put_bytes($urandom_range(1, 23));
        else if (kind == FK_NOISE) put_bytes($urandom_range(24, 40));
        else begin
            if (kind == FK_MAGIC) begin
                put32(MAGIC_WORD);
                file_buf[$urandom_range(0, 3)] ^= 8'(1 << $urandom_range(0, 7));
            end else put32(MAGIC_WORD);
            if (kind == FK_VERSION) put32($urandom_range(0, 1) ? 32'd0 : {$urandom} | 32'd2);
            else put32(FORMAT_VER);
            n = $urandom_range(0, 3);
            if (kind == FK_TRUNC) begin
                if ($urandom_range(0, 3) == 0) put64(64'hFFFF_FFFF_FFFF_FFFF);
                else put64(n + $urandom_range(1, 2));
            end else put64(n);
            for (int e = 0; e < n; e++) put_entry();
            if (kind == FK_TRAIL) put_bytes($urandom_range(1, 6));
            if (kind == FK_TRUNC && n > 0 && $urandom_range(0, 1))
                repeat ($urandom_range(1, 3)) void'(file_buf.pop_back());
            h = FNV_BASIS;
            foreach (file_buf[i]) h = fnv_fold(h, file_buf[i]);
            if (kind == FK_CHECKSUM) h ^= 64'd1 << $urandom_range(0, 63);
            put64(h);
        end
        foreach (file_buf[i]) begin
            fb.b = file_buf[i];
            fb.fin = (i == file_buf.size() - 1);
            file_q = {file_q, fb};
        end
        files_built++;
    endfunction

    function automatic int pick_kind();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return FK_OK;
        if (r < 62) return FK_MAGIC;
        if (r < 69) return FK_VERSION;
        if (r < 78) return FK_TRUNC;
        if (r < 85) return FK_CHECKSUM;
        if (r < 90) return FK_SHORT;
        if (r < 96) return FK_TRAIL;
        return FK_NOISE;
    endfunction

    // ---------------- driver ----------------
    t_file_byte cur_req;
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            s_tvalid <= 1'b0;
        end else begin
            if (s_tvalid && s_tready) begin
                predict_tokens(s_tdata, s_tlast);
                bytes_sent++;
            end
            if (!s_tvalid || s_tready) begin
                if (file_q.size() > 0 && $urandom_range(0, 99) >= send_idle_pct) begin
                    cur_req = file_q.pop_front();
                    s_tvalid <= 1'b1;
                    s_tdata <= cur_req.b;
                    s_tlast <= cur_req.fin;
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // ---------------- monitor ----------------
    t_result exp_tok;
    always @(posedge i_clk) begin
        m_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
        if (i_rst_n && m_tvalid && m_tready) begin
            if (token_q.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("ERROR: unexpected token kind=%0d data=%h", m_tuser, m_tdata);
            end else begin
                exp_tok = token_q.pop_front();
                tokens_checked++;
                if (m_tuser != exp_tok.kind || m_tdata[7:0] != exp_tok.tbyte
                    || m_tdata[8] != exp_tok.is_list || m_tdata[9] != exp_tok.has_exp
                    || m_tdata[73:10] != exp_tok.exp_ms || m_tdata[74] != exp_tok.keep
                    || m_tdata[77:75] != exp_tok.verdict || m_tlast != exp_tok.last) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display({"ERROR: token %0d exp kind=%0d byte=%h list=%b exp=%b ",
                                  "ms=%h keep=%b vd=%0d last=%b | got kind=%0d byte=%h ",
                                  "list=%b exp=%b ms=%h keep=%b vd=%0d last=%b"},
                                 tokens_checked, exp_tok.kind, exp_tok.tbyte,
                                 exp_tok.is_list, exp_tok.has_exp, exp_tok.exp_ms,
                                 exp_tok.keep, exp_tok.verdict, exp_tok.last,
                                 m_tuser, m_tdata[7:0], m_tdata[8], m_tdata[9],
                                 m_tdata[73:10], m_tdata[74], m_tdata[77:75], m_tlast);
                end
            end
        end
    end

    // ---------------- sequence ----------------
    task automatic wait_drained();
        while (file_q.size() > 0 || s_tvalid || token_q.size() > 0) @(posedge i_clk);
        repeat (10) @(posedge i_clk);
    endtask

    task automatic write_load_time(input logic [63:0] v);
        @(posedge i_clk);
        i_cfg_wen <= 1'b1;
        i_cfg_wdata <= v;
        load_time = v;
        @(posedge i_clk);
        i_cfg_wen <= 1'b0;
    endtask

    task automatic run_random(input int nbytes, input int s_idle, input int r_idle);
        int start;
        send_idle_pct = s_idle;
        recv_idle_pct = r_idle;
        start = bytes_sent + file_q.size();
        while (bytes_sent + file_q.size() - start < nbytes) queue_file(pick_kind());
        wait_drained();
    endtask

    initial begin
        load_time = '0;
        clear_parser();
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: one-byte file, short file, well-formed file
        write_load_time(64'd1000);
        file_q = {file_q, t_file_byte'{8'h00, 1'b1}};
        file_q = {file_q, t_file_byte'{8'hFF, 1'b0}};
        file_q = {file_q, t_file_byte'{8'h5A, 1'b1}};
        queue_file(FK_OK);
        wait_drained();

        write_load_time(64'h8000_0000_0000_0000);
        run_random(105, 18, 88);
        write_load_time(64'h7FFF_FFFF_FFFF_FFFF);
        run_random(105, 88, 18);
        write_load_time({$urandom, $urandom});
        run_random(105, 0, 0);

        if (token_q.size() != 0) mismatches++;
        $display("Streamed %0d files (%0d bytes), %0d tokens compared, %0d mismatches.",
                 files_built, bytes_sent, tokens_checked, mismatches);
        if (mismatches == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

    initial begin
        #2000000;
        $display("Timeout with %0d tokens still expected.", token_q.size());
        $display("[FAIL] regression broken");
        $finish;
    end

endmodule

// File: sim.f
rtl/sfp_pkg.sv
rtl/sfp_front.sv
rtl/sfp_parser.sv
rtl/sfp_outq.sv
rtl/snapshot_format_parser.sv
tb/testbench.sv
